// ===== rtl/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character lookup for the Base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    // Pad character '='
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Number of valid bytes in a queued group
    localparam logic [1:0] NB_ONE   = 2'd1;
    localparam logic [1:0] NB_TWO   = 2'd2;
    localparam logic [1:0] NB_THREE = 2'd3;

    // Character position inside a four-character quad
    localparam logic [1:0] POS_0 = 2'd0;
    localparam logic [1:0] POS_1 = 2'd1;
    localparam logic [1:0] POS_2 = 2'd2;
    localparam logic [1:0] POS_3 = 2'd3;

    // One byte group handed from the front end to the back end
    typedef struct packed {
        logic [23:0] bits;    // first byte in [23:16]
        logic [1:0]  nbytes;  // valid bytes, one to three
        logic        last;    // group closes the message
    } t_group;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [7:0] sextet_char(input logic [5:0] s);
        logic [7:0] c;
        c = 8'h2F;
        if (s < 6'd26) begin
            c = 8'h41 + {2'b00, s};
        end else if (s < 6'd52) begin
            c = 8'h61 + {2'b00, s} - 8'd26;
        end else if (s < 6'd62) begin
            c = 8'h30 + {2'b00, s} - 8'd52;
        end else if (s == 6'd62) begin
            c = 8'h2B;
        end
        return c;
    endfunction

endpackage

// ===== rtl/b64e_byte_if.sv =====
// ----------------------------------------------------------------------------
// b64e_byte_if
// Valid/ready channel carrying raw message bytes.
// ----------------------------------------------------------------------------
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/b64e_char_if.sv =====
// ----------------------------------------------------------------------------
// b64e_char_if
// Valid/ready channel carrying encoded ASCII characters.
// ----------------------------------------------------------------------------
interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ascii_char;
    logic       last_char;

    modport source (output valid, output ascii_char, output last_char, input ready);
    modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

// ===== rtl/b64e_front.sv =====
// ----------------------------------------------------------------------------
// b64e_front
// Collects bytes into three-byte groups and pushes finished groups.
// ----------------------------------------------------------------------------
module b64e_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    b64e_byte_if.sink       i_byte,
    input  logic            i_full,
    output logic            o_push,
    output b64e_pkg::t_group o_grp
);

    logic [15:0] r_pend, n_pend;
    logic [1:0]  r_cnt,  n_cnt;
    logic        w_xfer;

    // Take a byte whenever the queue has room
    assign i_byte.ready = !i_full;
    assign w_xfer       = i_byte.valid && !i_full;

    // Group assembly
    always_comb begin
        n_pend = r_pend;
        n_cnt  = r_cnt;
        o_push = 1'b0;
        o_grp  = '0;
        if (w_xfer) begin
            priority if (r_cnt == 2'd0) begin
                if (!i_byte.last_byte) begin
                    n_pend = {i_byte.data_byte, 8'h00};
                    n_cnt  = 2'd1;
                end else begin
                    o_push      = 1'b1;
                    o_grp.bits  = {i_byte.data_byte, 16'h0000};
                    o_grp.nbytes = b64e_pkg::NB_ONE;
                end
            end else if (r_cnt == 2'd1) begin
                if (!i_byte.last_byte) begin
                    n_pend = {r_pend[15:8], i_byte.data_byte};
                    n_cnt  = 2'd2;
                end else begin
                    o_push      = 1'b1;
                    o_grp.bits  = {r_pend[15:8], i_byte.data_byte, 8'h00};
                    o_grp.nbytes = b64e_pkg::NB_TWO;
                end
            end else begin
                // two held bytes: group is complete
                o_push      = 1'b1;
                o_grp.bits  = {r_pend, i_byte.data_byte};
                o_grp.nbytes = b64e_pkg::NB_THREE;
            end
            o_grp.last = i_byte.last_byte;
            if (o_push) begin
                n_pend = '0;
                n_cnt  = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ===== rtl/b64e_queue.sv =====
// ----------------------------------------------------------------------------
// b64e_queue
// Two-entry group queue between the front and back ends.
// ----------------------------------------------------------------------------
module b64e_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64e_pkg::t_group i_grp,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output b64e_pkg::t_group o_grp
);

    b64e_pkg::t_group r_mem [2];
    logic             r_wptr, n_wptr;
    logic             r_rptr, n_rptr;
    logic [1:0]       r_cnt,  n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_grp   = r_mem[r_rptr];

    // Pointer and occupancy update
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = !r_wptr;
        end
        if (i_pop) begin
            n_rptr = !r_rptr;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ===== rtl/b64e_back.sv =====
// ----------------------------------------------------------------------------
// b64e_back
// Turns each queued group into four characters, one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module b64e_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  b64e_pkg::t_group i_grp,
    output logic             o_pop,
    b64e_char_if.source      o_char
);

    b64e_pkg::t_group r_grp,   n_grp;
    logic             r_busy,  n_busy;
    logic [1:0]       r_sel,   n_sel;
    logic             r_ovld,  n_ovld;
    logic [7:0]       r_ochar, n_ochar;
    logic             r_olast, n_olast;
    logic             w_adv;
    logic [5:0]       w_sextet;
    logic [7:0]       w_char;
    logic             w_pad;

    assign o_char.valid      = r_ovld;
    assign o_char.ascii_char = r_ochar;
    assign o_char.last_char  = r_olast;

    // Output register free or being drained this cycle
    assign w_adv = r_busy && (!r_ovld || o_char.ready);

    // Current character of the quad
    always_comb begin
        unique case (r_sel)
            b64e_pkg::POS_0: w_sextet = r_grp.bits[23:18];
            b64e_pkg::POS_1: w_sextet = r_grp.bits[17:12];
            b64e_pkg::POS_2: w_sextet = r_grp.bits[11:6];
            default:         w_sextet = r_grp.bits[5:0];
        endcase
        w_pad = ((r_sel == b64e_pkg::POS_2) && (r_grp.nbytes == b64e_pkg::NB_ONE)) ||
                ((r_sel == b64e_pkg::POS_3) && (r_grp.nbytes != b64e_pkg::NB_THREE));
        w_char = w_pad ? b64e_pkg::PAD_CHAR : b64e_pkg::sextet_char(w_sextet);
    end

    // Quad sequencing and output register
    always_comb begin
        n_grp   = r_grp;
        n_busy  = r_busy;
        n_sel   = r_sel;
        n_ochar = r_ochar;
        n_olast = r_olast;
        n_ovld  = r_ovld && !o_char.ready;
        o_pop   = i_valid && (!r_busy || (w_adv && (r_sel == b64e_pkg::POS_3)));
        if (w_adv) begin
            n_ovld  = 1'b1;
            n_ochar = w_char;
            n_olast = r_grp.last && (r_sel == b64e_pkg::POS_3);
            n_sel   = r_sel + 2'd1;
            if (r_sel == b64e_pkg::POS_3) begin
                n_busy = 1'b0;
            end
        end
        if (o_pop) begin
            n_grp  = i_grp;
            n_busy = 1'b1;
            n_sel  = b64e_pkg::POS_0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp   <= n_grp;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sel  <= b64e_pkg::POS_0;
            r_ovld <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_sel  <= n_sel;
            r_ovld <= n_ovld;
        end
    end

endmodule

// ===== rtl/base64_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming Base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
// Usage:
//   i_byte carries raw bytes (data_byte) with last_byte marking the end of a
//   message; o_char carries ASCII characters with last_char set on the final
//   character of the message. Both are valid/ready channels.
//   Every third byte, or a byte with last_byte set, closes a group that comes
//   out as four characters, padded with '=' when the group is short.
//   The first character of a group passes through the group queue, the group
//   register of the back end and the output register; the rest follow one
//   per cycle while the receiver is ready, out of a single output register.
//   A two-entry group queue lets input run ahead of output.
//   Reset (synchronous, active low) drops held bytes, queued groups and any
//   pending character; i_byte.ready is high in the first cycle after it.
//   When the receiver stalls, the current character holds; input keeps
//   being taken until the group queue fills, then i_byte.ready drops.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64e_byte_if.sink   i_byte,
    b64e_char_if.source o_char
);

    logic             w_push;
    logic             w_full;
    logic             w_qvalid;
    logic             w_pop;
    b64e_pkg::t_group w_in_grp;
    b64e_pkg::t_group w_q_grp;

    b64e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_grp   (w_in_grp)
    );

    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_grp   (w_in_grp),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_grp   (w_q_grp)
    );

    b64e_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qvalid),
        .i_grp   (w_q_grp),
        .o_pop   (w_pop),
        .o_char  (o_char)
    );

endmodule

// ===== rtl/b64e_checker.sv =====
// ----------------------------------------------------------------------------
// b64e_checker
// Port-level checks for the Base64 encoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64e_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_last
);

    // A stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_char) && $stable(i_out_last))
        else $error("stalled output character changed");

    // Only alphabet characters or the pad ever appear
    a_out_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            ((i_out_char >= 8'h41) && (i_out_char <= 8'h5A)) ||
            ((i_out_char >= 8'h61) && (i_out_char <= 8'h7A)) ||
            ((i_out_char >= 8'h30) && (i_out_char <= 8'h39)) ||
            (i_out_char == 8'h2B) || (i_out_char == 8'h2F) ||
            (i_out_char == 8'h3D))
        else $error("output character outside the Base64 set");

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // Reset empties the group queue, so input is taken right away
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_byte.ready),
    .i_out_valid (o_char.valid),
    .i_out_ready (o_char.ready),
    .i_out_char  (o_char.ascii_char),
    .i_out_last  (o_char.last_char)
);
